>>> rtl/latency_budget_monitor_unit_assert.svh
// Assertion macros for the latency budget monitor.
`ifndef LATENCY_BUDGET_MONITOR_UNIT_ASSERT_SVH
`define LATENCY_BUDGET_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LBM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lbm_pkg.sv
package lbm_pkg;

  localparam int TIME_W   = 20;
  localparam int COUNT_W  = 16;
  localparam int OVR_W    = 27;
  localparam int WORD_W   = 32;
  // shared divider: dividend covers the largest window sum and time*100
  localparam int DIV_W    = 27;
  localparam int DVSR_W   = 20;

  localparam logic [TIME_W-1:0]  DEFAULT_BUDGET = 20'd2000;
  localparam logic [COUNT_W-1:0] CALL_MAX       = 16'hFFFF;
  localparam int                 OVR_SCALE      = 100;

  typedef enum logic [1:0] {
    CMD_RECORD      = 2'd0,
    CMD_SET_BUDGET  = 2'd1,
    CMD_FRAME_TICK  = 2'd2,
    CMD_RESET_STATS = 2'd3
  } lbm_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOOKUP,
    ST_UPDATE,
    ST_DIV_AVG,
    ST_DIV_OVR,
    ST_FINISH
  } lbm_state_t;

  typedef struct packed {
    lbm_cmd_t          command;
    logic [2:0]        source_id;
    logic [TIME_W-1:0] time_us;
    logic [TIME_W-1:0] budget_us;
  } lbm_request_t;

  typedef struct packed {
    logic               rejected;
    logic               violation;
    logic [OVR_W-1:0]   overage_pct;
    logic [TIME_W-1:0]  average_us;
    logic [TIME_W-1:0]  peak_us;
    logic [COUNT_W-1:0] call_count;
    logic [WORD_W-1:0]  frame_number;
    logic [WORD_W-1:0]  total_violations;
  } lbm_result_t;

endpackage

>>> rtl/lbm_divider.sv
// Restoring divider, one quotient bit per cycle.
module lbm_divider import lbm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic              fin,
  output logic [DIV_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(DIV_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

  logic              running;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  dvd;
  logic [DVSR_W-1:0] dvsr;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W:0]   rem_sh;
  logic [DVSR_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem, dvd[DIV_W-1]};
    ge      = rem_sh >= {1'b0, dvsr};
    rem_sub = rem_sh - {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      step    <= '0;
    end else begin
      fin <= 1'b0;
      if (go) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (go) begin
      dvd  <= dividend;
      dvsr <= divisor;
      rem  <= '0;
    end else if (running) begin
      dvd <= {dvd[DIV_W-2:0], ge};
      rem <= ge ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
    end
  end

  assign quotient = dvd;

endmodule

>>> rtl/lbm_sample_ram.sv
// Window sample store: one write port, one registered read port.
module lbm_sample_ram import lbm_pkg::*; #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [TIME_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/latency_budget_monitor_unit.sv
// Latency budget monitor. Each item is one command for one source: record a
// measured time, set a budget, advance the frame, or clear the statistics.
// Every accepted item (start high while busy is low) yields exactly one result,
// shown on result for the single cycle in which done is high; the receiver
// cannot stall, so it must take the result in that cycle. Set budget, frame
// tick, reset stats and records of unknown sources pass through read, lookup
// and finish; a record also passes through update and the one shared
// restoring divider, which takes 27 steps for the window average and, for a
// record over budget, 27 more for the overage percent.
// A new item may be started in the cycle that done is high.
`include "latency_budget_monitor_unit_assert.svh"

module latency_budget_monitor_unit import lbm_pkg::*; #(
  parameter int NUM_SOURCES = 8,
  parameter int WINDOW      = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  lbm_request_t request,
  output logic         done,
  output lbm_result_t  result
);

  localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int HEAD_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = TIME_W + $clog2(WINDOW);
  localparam int SLOTS  = NUM_SOURCES * WINDOW;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // per-source statistics word
  typedef struct packed {
    logic [TIME_W-1:0]  peak;
    logic [TIME_W-1:0]  avg;
    logic [COUNT_W-1:0] cnt;
    logic [SUM_W-1:0]   sum;
    logic [FILL_W-1:0]  fill;
    logic [HEAD_W-1:0]  head;
  } src_rec_t;

  lbm_state_t state, state_next;
  lbm_request_t req;

  logic [8:0]       src_wide;
  logic [SRC_W-1:0] src_idx;
  logic             src_valid;

  // stats and budget stores; valid bits stand in for the reset values
  src_rec_t          stat_mem [NUM_SOURCES];
  logic [TIME_W-1:0] bud_mem  [NUM_SOURCES];
  src_rec_t          rec_rd;
  logic [TIME_W-1:0] bud_rd;
  logic [NUM_SOURCES-1:0] stat_vld;  // cleared by reset stats
  logic [NUM_SOURCES-1:0] cnt_vld;   // cleared by frame tick and reset stats
  logic [NUM_SOURCES-1:0] bud_vld;   // cleared by rst only

  src_rec_t          rec;
  src_rec_t          rec_masked;
  logic [TIME_W-1:0] budget;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_lookup;
  logic [TIME_W-1:0] sample_rd;

  logic               full;
  logic [SUM_W-1:0]   sum_next;
  logic [FILL_W-1:0]  fill_next;
  logic [HEAD_W-1:0]  head_next;
  logic [TIME_W-1:0]  peak_next;
  logic [COUNT_W-1:0] cnt_next;
  logic               over;
  logic [TIME_W-1:0]  diff;

  logic             viol_flag;
  logic [OVR_W-1:0] overage;
  logic [DIV_W-1:0] ovr_dvd;

  logic              div_go;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVSR_W-1:0] div_divisor;
  logic              div_fin;
  logic [DIV_W-1:0]  div_quot;

  logic [WORD_W-1:0] frame_cnt, frame_next;
  logic [WORD_W-1:0] viol_cnt, viol_next;

  logic rec_write;
  logic bud_write;

  // ---------------------------------------------------------------- decode
  assign src_wide  = {6'd0, req.source_id};
  assign src_idx   = src_wide[SRC_W-1:0];
  assign src_valid = {4'd0, req.source_id} < 7'(NUM_SOURCES);

  assign rec_write = (state == ST_FINISH) && (req.command == CMD_RECORD) && src_valid;
  assign bud_write = (state == ST_FINISH) && (req.command == CMD_SET_BUDGET) &&
                     (req.budget_us != '0) && src_valid;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= request;
    end
  end

  // ---------------------------------------------------------------- stores
  always_ff @(posedge clk) begin
    if (rec_write) begin
      stat_mem[src_idx] <= rec;
    end
    if (bud_write) begin
      bud_mem[src_idx] <= req.budget_us;
    end
    rec_rd <= stat_mem[src_idx];
    bud_rd <= bud_mem[src_idx];
  end

  always_comb begin
    rec_masked     = stat_vld[src_idx] ? rec_rd : '0;
    rec_masked.cnt = cnt_vld[src_idx] ? rec_rd.cnt : '0;
    slot_lookup    = SLOT_W'(src_idx) * SLOT_W'(WINDOW) + SLOT_W'(rec_masked.head);
  end

  // the oldest sample is read only once the window is full, so it was written
  lbm_sample_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W)
  ) u_samples (
    .clk   (clk),
    .we    (state == ST_UPDATE),
    .waddr (slot),
    .wdata (req.time_us),
    .raddr (slot_lookup),
    .rdata (sample_rd)
  );

  // ---------------------------------------------------------------- update
  always_comb begin
    full      = rec.fill == FILL_W'(WINDOW);
    sum_next  = rec.sum - (full ? SUM_W'(sample_rd) : SUM_W'(0)) + SUM_W'(req.time_us);
    fill_next = full ? rec.fill : rec.fill + FILL_W'(1);
    head_next = (rec.head == HEAD_W'(WINDOW - 1)) ? '0 : rec.head + HEAD_W'(1);
    peak_next = (req.time_us > rec.peak) ? req.time_us : rec.peak;
    cnt_next  = (rec.cnt == CALL_MAX) ? rec.cnt : rec.cnt + COUNT_W'(1);
    over      = req.time_us > budget;
    diff      = req.time_us - budget;
  end

  // one divider: window average first, then overage percent on a violation
  assign div_dividend = (state == ST_UPDATE) ? DIV_W'(sum_next) : ovr_dvd;
  assign div_divisor  = (state == ST_UPDATE) ? DVSR_W'(fill_next) : budget;

  lbm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .fin      (div_fin),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    case (state)
      ST_LOOKUP: begin
        rec       <= rec_masked;
        budget    <= bud_vld[src_idx] ? bud_rd : DEFAULT_BUDGET;
        slot      <= slot_lookup;
        viol_flag <= 1'b0;
        overage   <= '0;
      end
      ST_UPDATE: begin
        rec.sum   <= sum_next;
        rec.fill  <= fill_next;
        rec.head  <= head_next;
        rec.peak  <= peak_next;
        rec.cnt   <= cnt_next;
        viol_flag <= over;
        ovr_dvd   <= DIV_W'(diff) * DIV_W'(OVR_SCALE);
      end
      ST_DIV_AVG: begin
        if (div_fin) begin
          rec.avg <= div_quot[TIME_W-1:0];
        end
      end
      ST_DIV_OVR: begin
        if (div_fin) begin
          overage <= div_quot[OVR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (req.command == CMD_RECORD && src_valid) state_next = ST_UPDATE;
        else                                        state_next = ST_FINISH;
      end
      ST_UPDATE: begin
        div_go     = 1'b1;
        state_next = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        if (div_fin) begin
          if (viol_flag) begin
            div_go     = 1'b1;
            state_next = ST_DIV_OVR;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_DIV_OVR: begin
        if (div_fin) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // ---------------------------------------------------------------- counters
  always_comb begin
    frame_next = frame_cnt;
    viol_next  = viol_flag ? viol_cnt + WORD_W'(1) : viol_cnt;
    case (req.command)
      CMD_FRAME_TICK:  frame_next = frame_cnt + WORD_W'(1);
      CMD_RESET_STATS: begin
        frame_next = '0;
        viol_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      frame_cnt <= '0;
      viol_cnt  <= '0;
      stat_vld  <= '0;
      cnt_vld   <= '0;
      bud_vld   <= '0;
    end else begin
      done <= (state == ST_FINISH);
      if (state == ST_FINISH) begin
        frame_cnt <= frame_next;
        viol_cnt  <= viol_next;
        case (req.command)
          CMD_RECORD: begin
            if (src_valid) begin
              stat_vld[src_idx] <= 1'b1;
              cnt_vld[src_idx]  <= 1'b1;
            end
          end
          CMD_SET_BUDGET: begin
            if (bud_write) bud_vld[src_idx] <= 1'b1;
          end
          CMD_FRAME_TICK: begin
            cnt_vld <= '0;
          end
          default: begin
            stat_vld <= '0;
            cnt_vld  <= '0;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      result.rejected    <= (req.command == CMD_SET_BUDGET) && (req.budget_us == '0);
      result.violation   <= viol_flag;
      result.overage_pct <= viol_flag ? overage : '0;
      result.average_us  <= (src_valid && req.command != CMD_RESET_STATS) ? rec.avg : '0;
      result.peak_us     <= (src_valid && req.command != CMD_RESET_STATS) ? rec.peak : '0;
      result.call_count  <= (src_valid && req.command != CMD_RESET_STATS &&
                             req.command != CMD_FRAME_TICK) ? rec.cnt : '0;
      result.frame_number     <= frame_next;
      result.total_violations <= viol_next;
    end
  end

  // ---------------------------------------------------------------- checks
  `LBM_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `LBM_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "item accepted but not busy")
  `LBM_ASSERT_IMPL(a_quiet_overage, clk, rst, done && !result.violation,
    result.overage_pct == '0, "overage without violation")
  `LBM_ASSERT_IMPL(a_flag_excl, clk, rst, done,
    !(result.rejected && result.violation), "rejected and violation together")

endmodule
